FILE: hdl/htwd_pkg.sv
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and constants of the Huffman tree walk decoder: the command
// and status codes and the transaction payloads of both channels.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int SYM_FIELD_W = 8;

    typedef enum logic [1:0] {
        CMD_INTERNAL = 2'd0,
        CMD_LEAF     = 2'd1,
        CMD_DECODE   = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_LOAD_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                   command;
        logic [SYM_FIELD_W-1:0] leaf_value;
        logic                   code_bit;
    } t_in_item;

    typedef struct packed {
        logic [SYM_FIELD_W-1:0] symbol;
        t_status                status;
    } t_out_item;

    typedef struct packed {
        logic left;
        logic right;
    } t_node_we;

endpackage

FILE: hdl/htwd_node_mem.sv
// ----------------------------------------------------------------------------
// htwd_node_mem
// Child tables of the node memory. Each entry holds the left and the right
// child of a node together with the child's leaf flag and symbol.
// ----------------------------------------------------------------------------
module htwd_node_mem #(
    parameter int DEPTH = 512,
    parameter int DATA_W = 18,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  htwd_pkg::t_node_we  i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [DATA_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [DATA_W-1:0]   o_rdata_l,
    output logic [DATA_W-1:0]   o_rdata_r
);
    import htwd_pkg::*;

    logic [DATA_W-1:0] r_left  [DEPTH];
    logic [DATA_W-1:0] r_right [DEPTH];
    logic [DATA_W-1:0] r_rd_l;
    logic [DATA_W-1:0] r_rd_r;

    always_ff @(posedge i_clk) begin
        if (i_we.left) begin
            r_left[i_waddr] <= i_wdata;
        end
        if (i_we.right) begin
            r_right[i_waddr] <= i_wdata;
        end
        r_rd_l <= r_left[i_raddr];
        r_rd_r <= r_right[i_raddr];
    end

    assign o_rdata_l = r_rd_l;
    assign o_rdata_r = r_rd_r;

endmodule

FILE: hdl/htwd_stack_mem.sv
// ----------------------------------------------------------------------------
// htwd_stack_mem
// Storage for the parents below the top of the parent stack. The read port
// is registered and returns the written data when both ports meet.
// ----------------------------------------------------------------------------
module htwd_stack_mem #(
    parameter int DEPTH = 256,
    parameter int DATA_W = 9,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rd <= i_wdata;
        end else begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;

endmodule

FILE: hdl/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Huffman decoder that builds its tree from a preorder load stream and then
// walks it one code bit per transaction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries commands: load an internal node, load a leaf,
// decode one code bit, or clear the tree. A tree is loaded in preorder and is
// complete when the last open parent receives its right child. The output
// channel carries a symbol with status OK when a decode bit reaches a leaf,
// status 1 when a bit arrives before the tree is complete, and status 2 when
// a load overflows or comes after a complete tree. Other transactions give
// no result.
// Each node entry stores its children's leaf flags and symbols, and the root
// entry is held in registers, so a code bit needs a single node memory read.
// The block takes one transaction per cycle while the receiver does not
// stall. A result passes the input register, loaded when its transaction is
// accepted, and then the output register, loaded when the transaction fires.
// Reset empties the tree and the walk and needs no clearing pass. While the
// receiver stalls, the output register holds its transaction, one more
// transaction waits in the input register, and then o_in_stall is raised.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
    parameter int MAX_NODES = 512,
    parameter int STACK_DEPTH = 256,
    parameter int SYMBOL_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  htwd_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htwd_pkg::t_out_item o_out_data
);
    import htwd_pkg::*;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W   = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;
    localparam int CHILD_W = NODE_W + 1 + SYM_W;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [NCNT_W-1:0]  r_nodes_used, n_nodes_used;
    logic [LVL_W-1:0]   r_level, n_level;
    logic               r_complete, n_complete;
    logic [NODE_W-1:0]  r_top_node, n_top_node;
    logic               r_top_ldone, n_top_ldone;
    logic [NODE_W-1:0]  r_cur_node, n_cur_node;
    logic               r_at_root, n_at_root;
    logic               r_root_leaf, n_root_leaf;
    logic [SYM_W-1:0]   r_root_sym, n_root_sym;
    logic [CHILD_W-1:0] r_root_l, n_root_l;
    logic [CHILD_W-1:0] r_root_r, n_root_r;

    logic               s_fire;
    logic               s_in_take;
    logic               s_is_leaf;
    logic [SYM_W-1:0]   s_sym;
    logic [NODE_W-1:0]  s_new_idx;
    logic [CHILD_W-1:0] s_new_child;
    logic               s_pops;
    logic [LVL_W-1:0]   s_lvl_after;
    logic               s_load_err;
    logic [NODE_W-1:0]  s_below;
    logic [NODE_W-1:0]  s_eff_node;
    logic [CHILD_W-1:0] s_mem_l, s_mem_r;
    logic [CHILD_W-1:0] s_child;
    t_node_we           s_node_we;
    logic               s_stk_we;
    logic [SP_W-1:0]    s_stk_waddr;
    logic [LVL_W-1:0]   s_stk_rlvl;
    logic               s_res_valid;
    t_out_item          s_res;

    assign s_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign s_in_take  = i_in_valid && !o_in_stall;

    assign s_is_leaf   = (r_in.command == CMD_LEAF);
    assign s_sym       = r_in.leaf_value[SYM_W-1:0];
    assign s_new_idx   = r_nodes_used[NODE_W-1:0];
    assign s_new_child = {s_new_idx, s_is_leaf, s_sym};
    assign s_pops      = (r_nodes_used != '0) && r_top_ldone;
    assign s_eff_node  = s_pops ? s_below : r_top_node;
    assign s_child     = r_in.code_bit ? (r_at_root ? r_root_r : s_mem_r)
                                       : (r_at_root ? r_root_l : s_mem_l);

    always_comb begin
        if (r_nodes_used == '0) begin
            s_lvl_after = '0;
        end else if (s_pops) begin
            s_lvl_after = r_level - LVL_W'(1);
        end else begin
            s_lvl_after = r_level;
        end
        s_load_err = r_complete
                  || (r_nodes_used >= NCNT_W'(MAX_NODES))
                  || ((r_nodes_used != '0) && (r_level == '0))
                  || (!s_is_leaf && (s_lvl_after >= LVL_W'(STACK_DEPTH)));
    end

    always_comb begin
        n_nodes_used = r_nodes_used;
        n_level      = r_level;
        n_complete   = r_complete;
        n_top_node   = r_top_node;
        n_top_ldone  = r_top_ldone;
        n_cur_node   = r_cur_node;
        n_at_root    = r_at_root;
        n_root_leaf  = r_root_leaf;
        n_root_sym   = r_root_sym;
        n_root_l     = r_root_l;
        n_root_r     = r_root_r;
        s_node_we    = '0;
        s_stk_we     = 1'b0;
        s_stk_waddr  = '0;
        s_res_valid  = 1'b0;
        s_res        = '0;
        if (s_fire) begin
            unique case (r_in.command)
                CMD_INTERNAL, CMD_LEAF: begin
                    if (s_load_err) begin
                        s_res_valid  = 1'b1;
                        s_res.status = ST_LOAD_ERROR;
                    end else begin
                        n_nodes_used = r_nodes_used + NCNT_W'(1);
                        if (r_nodes_used == '0) begin
                            n_root_leaf = s_is_leaf;
                            n_root_sym  = s_sym;
                        end else begin
                            s_node_we.right = s_pops;
                            s_node_we.left  = !s_pops;
                            if (r_top_node == '0) begin
                                if (s_pops) begin
                                    n_root_r = s_new_child;
                                end else begin
                                    n_root_l = s_new_child;
                                end
                            end
                        end
                        n_top_node  = s_eff_node;
                        n_top_ldone = 1'b1;
                        n_level     = s_lvl_after;
                        if (s_is_leaf) begin
                            if (s_lvl_after == '0) begin
                                n_complete = 1'b1;
                                n_cur_node = '0;
                                n_at_root  = 1'b1;
                            end
                        end else begin
                            if (s_lvl_after != '0) begin
                                s_stk_we    = 1'b1;
                                s_stk_waddr = SP_W'(s_lvl_after - LVL_W'(1));
                            end
                            n_top_node  = s_new_idx;
                            n_top_ldone = 1'b0;
                            n_level     = s_lvl_after + LVL_W'(1);
                        end
                    end
                end
                CMD_DECODE: begin
                    if (!r_complete) begin
                        s_res_valid  = 1'b1;
                        s_res.status = ST_INCOMPLETE;
                    end else if (r_root_leaf) begin
                        s_res_valid  = 1'b1;
                        s_res.status = ST_OK;
                        s_res.symbol = SYM_FIELD_W'(r_root_sym);
                        n_cur_node   = '0;
                        n_at_root    = 1'b1;
                    end else if (s_child[SYM_W]) begin
                        s_res_valid  = 1'b1;
                        s_res.status = ST_OK;
                        s_res.symbol = SYM_FIELD_W'(s_child[SYM_W-1:0]);
                        n_cur_node   = '0;
                        n_at_root    = 1'b1;
                    end else begin
                        n_cur_node = s_child[CHILD_W-1 -: NODE_W];
                        n_at_root  = 1'b0;
                    end
                end
                CMD_CLEAR: begin
                    n_nodes_used = '0;
                    n_level      = '0;
                    n_complete   = 1'b0;
                    n_cur_node   = '0;
                    n_at_root    = 1'b1;
                end
                default: begin
                    n_level = r_level;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (s_fire) begin
            n_out_valid = s_res_valid;
            n_out       = s_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign s_stk_rlvl = n_level - LVL_W'(2);

    htwd_node_mem #(
        .DEPTH  (MAX_NODES),
        .DATA_W (CHILD_W)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_we      (s_node_we),
        .i_waddr   (r_top_node),
        .i_wdata   (s_new_child),
        .i_raddr   (n_cur_node),
        .o_rdata_l (s_mem_l),
        .o_rdata_r (s_mem_r)
    );

    htwd_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (NODE_W)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (s_stk_we),
        .i_waddr (s_stk_waddr),
        .i_wdata (s_eff_node),
        .i_raddr (s_stk_rlvl[SP_W-1:0]),
        .o_rdata (s_below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_nodes_used <= '0;
            r_level      <= '0;
            r_complete   <= 1'b0;
            r_top_ldone  <= 1'b0;
            r_cur_node   <= '0;
            r_at_root    <= 1'b1;
        end else begin
            if (s_in_take) begin
                r_in_valid <= 1'b1;
            end else if (s_fire) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid  <= n_out_valid;
            r_nodes_used <= n_nodes_used;
            r_level      <= n_level;
            r_complete   <= n_complete;
            r_top_ldone  <= n_top_ldone;
            r_cur_node   <= n_cur_node;
            r_at_root    <= n_at_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in <= i_in_data;
        end
        r_out       <= n_out;
        r_top_node  <= n_top_node;
        r_root_leaf <= n_root_leaf;
        r_root_sym  <= n_root_sym;
        r_root_l    <= n_root_l;
        r_root_r    <= n_root_r;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/htwd_checker.sv
// ----------------------------------------------------------------------------
// htwd_checker
// Port-level checks of the Huffman tree walk decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htwd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input htwd_pkg::t_out_item o_out_data
);
    import htwd_pkg::*;

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output transaction dropped while stalled.");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("Output payload changed while stalled.");

    a_no_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("Result presented right after reset.");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("Input stalled without a stalled output.");

    a_error_symbol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> (o_out_data.symbol == '0))
        else $error("Nonzero symbol with an error status.");

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
